// ----- hdl/fadr_pkg.sv -----
// ----------------------------------------------------------------------------
// fadr_pkg
// shared widths, command and status types for the fraction add/reduce unit
// ----------------------------------------------------------------------------
package fadr_pkg;

   // operand width of the numerators; denominators are one bit narrower
   localparam int OPERAND_WIDTH = 16;
   localparam int DEN_IN_W      = OPERAND_WIDTH - 1;

   // exact cross-multiplied sum, signed
   localparam int SUM_W         = 2 * OPERAND_WIDTH;
   // magnitude of the sum and product denominator both fit here
   localparam int DIV_W         = 2 * OPERAND_WIDTH - 1;
   // divider bit counter and gcd power-of-two count
   localparam int DIV_CNT_W     = $clog2(DIV_W);
   localparam int SHIFT_W       = $clog2(DIV_W);

   // result field widths
   localparam int NUM_OUT_W     = 32;
   localparam int DEN_OUT_W     = 30;

   typedef enum logic [1:0] {
      MUL_NUM_A,
      MUL_NUM_B,
      MUL_DEN
   } mul_sel_type;

   typedef enum logic {
      DIV_SRC_NUM,
      DIV_SRC_DEN
   } div_src_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        sum_en;
      logic        gcd_step;
      logic        div_init;
      div_src_type div_src;
      logic        div_step;
      logic        quo_num_store;
      logic        out_load;
   } fadr_cmd_type;

   typedef struct packed {
      logic zero_den;
      logic gcd_done;
   } fadr_status_type;

endpackage

// ----- hdl/fadr_datapath.sv -----
// ----------------------------------------------------------------------------
// fadr_datapath
// operand registers, shared multiplier, binary gcd, shared restoring divider
// ----------------------------------------------------------------------------
module fadr_datapath
   import fadr_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic signed [OPERAND_WIDTH-1:0] req_first_numerator,
   input  logic        [DEN_IN_W-1:0]  req_first_denominator,
   input  logic signed [OPERAND_WIDTH-1:0] req_second_numerator,
   input  logic        [DEN_IN_W-1:0]  req_second_denominator,
   input  fadr_cmd_type                cmd,
   output fadr_status_type             status,
   output logic signed [NUM_OUT_W-1:0] rsp_sum_numerator,
   output logic        [DEN_OUT_W-1:0] rsp_sum_denominator,
   output logic                        rsp_zero_denominator_error
);

   logic signed [OPERAND_WIDTH-1:0] n1_ff, n2_ff;
   logic        [DEN_IN_W-1:0]      d1_ff, d2_ff;
   logic signed [SUM_W-1:0]         prod_a_ff, prod_b_ff;
   logic        [DIV_W-1:0]         den_ff, mag_ff;
   logic                            neg_ff;
   logic        [DIV_W-1:0]         a_ff, b_ff;
   logic        [SHIFT_W-1:0]       k_ff;
   logic        [DIV_W-1:0]         dq_ff, rem_ff, divisor_ff;
   logic        [DIV_W-1:0]         quo_num_ff;
   logic signed [NUM_OUT_W-1:0]     out_num_ff;
   logic        [DEN_OUT_W-1:0]     out_den_ff;
   logic                            out_err_ff;

   logic signed [OPERAND_WIDTH-1:0] mul_a, mul_b;
   logic signed [SUM_W-1:0]         product;
   logic signed [SUM_W-1:0]         sum, mag_full;
   logic        [DIV_W-1:0]         a_in, b_in;
   logic        [SHIFT_W-1:0]       k_in;
   logic        [DIV_W-1:0]         gcd_val;
   logic        [DIV_W:0]           rem_sh, diff;
   logic                            zero_den;
   logic signed [SUM_W-1:0]         num_signed;

   assign zero_den = (d1_ff == '0) || (d2_ff == '0);
   assign status.zero_den = zero_den;
   assign status.gcd_done = (a_ff == '0);

   // operand select for the one multiplier
   always_comb begin
      case (cmd.mul_sel)
         MUL_NUM_A: begin
            mul_a = n1_ff;
            mul_b = $signed({1'b0, d2_ff});
         end
         MUL_NUM_B: begin
            mul_a = n2_ff;
            mul_b = $signed({1'b0, d1_ff});
         end
         MUL_DEN: begin
            mul_a = $signed({1'b0, d1_ff});
            mul_b = $signed({1'b0, d2_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product  = SUM_W'(mul_a) * SUM_W'(mul_b);
   assign sum      = prod_a_ff + prod_b_ff;
   assign mag_full = sum[SUM_W-1] ? (SUM_W'(0) - sum) : sum;

   // one binary gcd step
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      k_in = k_ff;
      if (!a_ff[0] && !b_ff[0]) begin
         a_in = a_ff >> 1;
         b_in = b_ff >> 1;
         k_in = k_ff + SHIFT_W'(1);
      end else if (!a_ff[0]) begin
         a_in = a_ff >> 1;
      end else if (!b_ff[0]) begin
         b_in = b_ff >> 1;
      end else if (a_ff >= b_ff) begin
         a_in = a_ff - b_ff;
      end else begin
         b_in = b_ff - a_ff;
      end
   end

   assign gcd_val = b_ff << k_ff;

   // restoring divider trial subtract
   assign rem_sh = {rem_ff, dq_ff[DIV_W-1]};
   assign diff   = rem_sh - {1'b0, divisor_ff};

   assign num_signed = neg_ff ? (SUM_W'(0) - SUM_W'(quo_num_ff)) : SUM_W'(quo_num_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n1_ff <= req_first_numerator;
         d1_ff <= req_first_denominator;
         n2_ff <= req_second_numerator;
         d2_ff <= req_second_denominator;
      end
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MUL_NUM_A: prod_a_ff <= product;
            MUL_NUM_B: prod_b_ff <= product;
            MUL_DEN:   den_ff    <= product[DIV_W-1:0];
            default:   prod_a_ff <= prod_a_ff;
         endcase
      end
      if (cmd.sum_en) begin
         neg_ff <= sum[SUM_W-1];
         mag_ff <= mag_full[DIV_W-1:0];
         a_ff   <= mag_full[DIV_W-1:0];
         b_ff   <= den_ff;
         k_ff   <= '0;
      end else if (cmd.gcd_step) begin
         a_ff <= a_in;
         b_ff <= b_in;
         k_ff <= k_in;
      end
      if (cmd.div_init) begin
         dq_ff      <= (cmd.div_src == DIV_SRC_NUM) ? mag_ff : den_ff;
         rem_ff     <= '0;
         divisor_ff <= gcd_val;
      end else if (cmd.div_step) begin
         if (!diff[DIV_W]) begin
            rem_ff <= diff[DIV_W-1:0];
            dq_ff  <= {dq_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[DIV_W-1:0];
            dq_ff  <= {dq_ff[DIV_W-2:0], 1'b0};
         end
      end
      if (cmd.quo_num_store) begin
         quo_num_ff <= dq_ff;
      end
      if (cmd.out_load) begin
         if (zero_den) begin
            out_num_ff <= '0;
            out_den_ff <= DEN_OUT_W'(1);
            out_err_ff <= 1'b1;
         end else begin
            out_num_ff <= NUM_OUT_W'(num_signed);
            out_den_ff <= DEN_OUT_W'(dq_ff);
            out_err_ff <= 1'b0;
         end
      end
   end

   assign rsp_sum_numerator          = out_num_ff;
   assign rsp_sum_denominator        = out_den_ff;
   assign rsp_zero_denominator_error = out_err_ff;

   // gcd operand b never reaches zero while stepping
   a_gcd_b_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.gcd_step |-> (b_ff != '0))
      else $error("gcd operand b is zero during a step");

   // divisor loaded into the divider is never zero
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_init |-> (gcd_val != '0))
      else $error("divider started with a zero divisor");

   // the gcd divides the numerator magnitude exactly
   a_num_exact: assert property (@(posedge clock) disable iff (reset)
      cmd.quo_num_store |-> (rem_ff == '0))
      else $error("numerator division left a remainder");

endmodule

// ----- hdl/fadr_ctrl.sv -----
// ----------------------------------------------------------------------------
// fadr_ctrl
// sequencer for multiply, sum, gcd and the two divisions; owns rsp_valid
// ----------------------------------------------------------------------------
module fadr_ctrl
   import fadr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  fadr_status_type status,
   output fadr_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_SUM,
      ST_GCD,
      ST_DIV_NUM_INIT,
      ST_DIV_NUM,
      ST_DIV_DEN_INIT,
      ST_DIV_DEN,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 cnt_last;

   assign cnt_last  = (cnt_ff == DIV_CNT_W'(DIV_W - 1));
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.mul_sel  = MUL_NUM_A;
      cmd.div_src  = DIV_SRC_NUM;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            if (status.zero_den) begin
               state_in = ST_DONE;
            end else begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = MUL_NUM_A;
               state_in    = ST_MUL_B;
            end
         end
         ST_MUL_B: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_NUM_B;
            state_in    = ST_MUL_C;
         end
         ST_MUL_C: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DEN;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_GCD;
         end
         ST_GCD: begin
            if (status.gcd_done) begin
               state_in = ST_DIV_NUM_INIT;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV_NUM_INIT: begin
            cmd.div_init = 1'b1;
            cmd.div_src  = DIV_SRC_NUM;
            state_in     = ST_DIV_NUM;
         end
         ST_DIV_NUM: begin
            cmd.div_step = 1'b1;
            if (cnt_last) begin
               state_in = ST_DIV_DEN_INIT;
            end else begin
               cnt_in = cnt_ff + DIV_CNT_W'(1);
            end
         end
         ST_DIV_DEN_INIT: begin
            cmd.quo_num_store = 1'b1;
            cmd.div_init      = 1'b1;
            cmd.div_src       = DIV_SRC_DEN;
            state_in          = ST_DIV_DEN;
         end
         ST_DIV_DEN: begin
            cmd.div_step = 1'b1;
            if (cnt_last) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + DIV_CNT_W'(1);
            end
         end
         ST_DONE: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // bit counter rests at zero outside the divisions
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DIV_NUM && state_ff != ST_DIV_DEN) |-> (cnt_ff == '0))
      else $error("divider counter running outside a division");

   // an accepted transfer starts the multiply sequence
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_MUL_A))
      else $error("accepted transfer did not start the sequence");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.out_load && rsp_valid_ff && rsp_stall))
      else $error("output register overwritten while stalled");

endmodule

// ----- hdl/fraction_add_reduce_unit.sv -----
// ----------------------------------------------------------------------------
// fraction_add_reduce_unit
// adds two fractions and reduces the sum to lowest terms
// ----------------------------------------------------------------------------
// sequence from accept to rsp_valid: three multiplies, sum, binary gcd loop,
// division of the numerator, division of the denominator, output load;
// division width DIV_W = 31; one item in flight; a zero denominator skips the
// multiplies, gcd and divisions and answers with the error flag set
// the next transfer is accepted while the previous result waits in rsp; the
// new result then holds until rsp is free; sync reset clears sequencer, rsp_valid
module fraction_add_reduce_unit
   import fadr_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [OPERAND_WIDTH-1:0] req_first_numerator,
   input  logic        [DEN_IN_W-1:0]      req_first_denominator,
   input  logic signed [OPERAND_WIDTH-1:0] req_second_numerator,
   input  logic        [DEN_IN_W-1:0]      req_second_denominator,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [NUM_OUT_W-1:0]     rsp_sum_numerator,
   output logic        [DEN_OUT_W-1:0]     rsp_sum_denominator,
   output logic                            rsp_zero_denominator_error
);

   // command and status between sequencer and datapath
   fadr_cmd_type    cmd;
   fadr_status_type status;

   // sequencer: multiply x3, sum, gcd loop, two divisions, output handoff
   fadr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: shared multiplier, binary gcd, one restoring divider used
   // for both the numerator and the denominator, and the output register
   fadr_datapath u_datapath (
      .clock                      (clock),
      .reset                      (reset),
      .req_first_numerator        (req_first_numerator),
      .req_first_denominator      (req_first_denominator),
      .req_second_numerator       (req_second_numerator),
      .req_second_denominator     (req_second_denominator),
      .cmd                        (cmd),
      .status                     (status),
      .rsp_sum_numerator          (rsp_sum_numerator),
      .rsp_sum_denominator        (rsp_sum_denominator),
      .rsp_zero_denominator_error (rsp_zero_denominator_error)
   );

endmodule
